### src/scpnl_pkg.sv
`timescale 1ns / 1ps

package scpnl_pkg;

  localparam int LINE_LIMIT    = 19;
  localparam int DIGIT_COUNT   = 8;
  localparam int STORE_DEPTH   = 9;
  localparam int DISPLAY_DEPTH = 8;
  localparam int PREFIX_LEN    = 8;
  localparam int LINE_CNT_W    = $clog2(LINE_LIMIT + 1);
  localparam int POS_W         = $clog2(DISPLAY_DEPTH);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int BEAT_W        = 3;

  localparam logic [BEAT_W-1:0] BEAT_K     = 3'd0;
  localparam logic [BEAT_W-1:0] BEAT_E     = 3'd1;
  localparam logic [BEAT_W-1:0] BEAT_Y     = 3'd2;
  localparam logic [BEAT_W-1:0] BEAT_COLON = 3'd3;
  localparam logic [BEAT_W-1:0] BEAT_DIGIT = 3'd4;
  localparam logic [BEAT_W-1:0] BEAT_CR    = 3'd5;
  localparam logic [BEAT_W-1:0] BEAT_LAST  = 3'd6;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_K     = 8'h4b;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_COLON = 8'h3a;

  localparam logic [7:0] CMD_PREFIX [PREFIX_LEN] = '{
    8'h44, 8'h49, 8'h53, 8'h50, 8'h4c, 8'h41, 8'h59, 8'h3a
  };

  typedef enum logic [1:0] {
    OP_RX_BYTE   = 2'd0,
    OP_KEY_CODE  = 2'd1,
    OP_SCAN_TICK = 2'd2,
    OP_UNUSED    = 2'd3
  } op_t;

  typedef struct packed {
    logic       is_key;
    logic [3:0] digit;
    logic [7:0] sel;
    logic [7:0] seg;
  } job_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] digit;
  } key_t;

  function automatic key_t key_decode(input logic [7:0] code);
    key_t k;
    k.hit = 1'b1;
    unique case (code)
      8'h7e:   k.digit = 4'd1;
      8'h7d:   k.digit = 4'd4;
      8'h7b:   k.digit = 4'd7;
      8'hbe:   k.digit = 4'd2;
      8'hbd:   k.digit = 4'd5;
      8'hbb:   k.digit = 4'd8;
      8'hb7:   k.digit = 4'd0;
      8'hde:   k.digit = 4'd3;
      8'hdd:   k.digit = 4'd6;
      8'hdb:   k.digit = 4'd9;
      default: begin
        k.hit   = 1'b0;
        k.digit = 4'd0;
      end
    endcase
    return k;
  endfunction

  function automatic logic [7:0] seg_of_digit(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

### src/scpnl_front.sv
`timescale 1ns / 1ps

module scpnl_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [1:0]             in_operation,
  input  logic [7:0]             in_data_byte,
  output logic                   in_stall,
  input  logic                   q_full,
  output logic                   q_push,
  output scpnl_pkg::job_t        q_push_job
);

  logic [scpnl_pkg::LINE_CNT_W-1:0] line_count_r, line_count_nxt;
  logic [7:0] line_store_r [scpnl_pkg::STORE_DEPTH];
  logic [7:0] line_store_nxt [scpnl_pkg::STORE_DEPTH];
  logic [7:0] disp_r [scpnl_pkg::DISPLAY_DEPTH];
  logic [7:0] disp_nxt [scpnl_pkg::DISPLAY_DEPTH];
  logic [scpnl_pkg::POS_W-1:0] scan_pos_r, scan_pos_nxt;

  scpnl_pkg::op_t  op;
  scpnl_pkg::key_t kd;
  logic            accept;
  logic            prefix_ok;
  logic            cmd_ok;
  logic            store_wr;
  logic            push_en;
  logic [3:0]      push_d;
  logic [scpnl_pkg::POS_W:0] pos_inc;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign op       = scpnl_pkg::op_t'(in_operation);
  assign kd       = scpnl_pkg::key_decode(in_data_byte);
  assign pos_inc  = {1'b0, scan_pos_r} + 1'b1;

  always_comb begin
    prefix_ok = 1'b1;
    for (int i = 0; i < scpnl_pkg::PREFIX_LEN; i++) begin
      if (line_store_r[i] != scpnl_pkg::CMD_PREFIX[i]) prefix_ok = 1'b0;
    end
    cmd_ok = (line_count_r >= scpnl_pkg::LINE_CNT_W'(scpnl_pkg::STORE_DEPTH)) && prefix_ok &&
             (line_store_r[scpnl_pkg::STORE_DEPTH-1] >= scpnl_pkg::CH_ZERO) &&
             (line_store_r[scpnl_pkg::STORE_DEPTH-1] <= scpnl_pkg::CH_NINE);
  end

  always_comb begin
    line_count_nxt = line_count_r;
    scan_pos_nxt   = scan_pos_r;
    store_wr       = 1'b0;
    push_en        = 1'b0;
    push_d         = 4'd0;
    q_push         = 1'b0;
    q_push_job     = '0;
    if (accept) begin
      unique case (op)
        scpnl_pkg::OP_RX_BYTE: begin
          if (line_count_r >= scpnl_pkg::LINE_CNT_W'(scpnl_pkg::LINE_LIMIT)) begin
            line_count_nxt = '0;
          end else if (in_data_byte == scpnl_pkg::CH_LF ||
                       in_data_byte == scpnl_pkg::CH_CR) begin
            if (cmd_ok) begin
              push_en = 1'b1;
              push_d  = 4'(line_store_r[scpnl_pkg::STORE_DEPTH-1] - scpnl_pkg::CH_ZERO);
            end
            line_count_nxt = '0;
          end else begin
            store_wr       = 1'b1;
            line_count_nxt = line_count_r + 1'b1;
          end
        end
        scpnl_pkg::OP_KEY_CODE: begin
          if (kd.hit) begin
            push_en           = 1'b1;
            push_d            = kd.digit;
            q_push            = 1'b1;
            q_push_job.is_key = 1'b1;
            q_push_job.digit  = kd.digit;
            q_push_job.sel    = 8'hff;
            q_push_job.seg    = 8'h00;
          end
        end
        scpnl_pkg::OP_SCAN_TICK: begin
          q_push            = 1'b1;
          q_push_job.is_key = 1'b0;
          q_push_job.sel    = ~(8'd1 << scan_pos_r);
          q_push_job.seg    = disp_r[scan_pos_r];
          if (pos_inc >= (scpnl_pkg::POS_W+1)'(scpnl_pkg::DIGIT_COUNT)) scan_pos_nxt = '0;
          else scan_pos_nxt = pos_inc[scpnl_pkg::POS_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < scpnl_pkg::STORE_DEPTH; i++) begin
      line_store_nxt[i] = (store_wr && line_count_r == scpnl_pkg::LINE_CNT_W'(i)) ?
                          in_data_byte : line_store_r[i];
    end
    for (int i = 0; i < scpnl_pkg::DISPLAY_DEPTH - 1; i++) begin
      disp_nxt[i] = push_en ? disp_r[i+1] : disp_r[i];
    end
    disp_nxt[scpnl_pkg::DISPLAY_DEPTH-1] = push_en ? scpnl_pkg::seg_of_digit(push_d) :
                                           disp_r[scpnl_pkg::DISPLAY_DEPTH-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= '0;
      scan_pos_r   <= '0;
      for (int i = 0; i < scpnl_pkg::DISPLAY_DEPTH; i++) disp_r[i] <= 8'h00;
    end else begin
      line_count_r <= line_count_nxt;
      scan_pos_r   <= scan_pos_nxt;
      for (int i = 0; i < scpnl_pkg::DISPLAY_DEPTH; i++) disp_r[i] <= disp_nxt[i];
    end
  end

  // line store is only examined once all nine entries were written this line
  always_ff @(posedge clk) begin
    for (int i = 0; i < scpnl_pkg::STORE_DEPTH; i++) line_store_r[i] <= line_store_nxt[i];
  end

endmodule

### src/scpnl_queue.sv
`timescale 1ns / 1ps

module scpnl_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  scpnl_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output scpnl_pkg::job_t head_job
);

  scpnl_pkg::job_t mem_r [scpnl_pkg::QUEUE_DEPTH];
  logic [scpnl_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [scpnl_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [scpnl_pkg::QPTR_W:0]   count_r, count_nxt;
  logic do_push, do_pop;

  assign full     = (count_r == (scpnl_pkg::QPTR_W+1)'(scpnl_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

### src/scpnl_back.sv
`timescale 1ns / 1ps

module scpnl_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  scpnl_pkg::job_t head_job,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_tx_valid,
  output logic [7:0]      out_tx_char,
  output logic [7:0]      out_digit_select,
  output logic [7:0]      out_segment_bits,
  output logic            out_last_of_run
);

  logic                          out_valid_r, out_valid_nxt;
  logic [scpnl_pkg::BEAT_W-1:0]  beat_r, beat_nxt;
  logic                          tx_valid_r, tx_valid_nxt;
  logic [7:0]                    tx_char_r, tx_char_nxt;
  logic [7:0]                    sel_r, sel_nxt;
  logic [7:0]                    seg_r, seg_nxt;
  logic                          last_r, last_nxt;
  logic                          load;
  logic                          last_beat;
  logic [7:0]                    key_char;

  assign load      = !q_empty && (!out_valid_r || !out_stall);
  assign last_beat = !head_job.is_key || (beat_r == scpnl_pkg::BEAT_LAST);
  assign q_pop     = load && last_beat;

  always_comb begin
    unique case (beat_r)
      scpnl_pkg::BEAT_K:     key_char = scpnl_pkg::CH_K;
      scpnl_pkg::BEAT_E:     key_char = scpnl_pkg::CH_E;
      scpnl_pkg::BEAT_Y:     key_char = scpnl_pkg::CH_Y;
      scpnl_pkg::BEAT_COLON: key_char = scpnl_pkg::CH_COLON;
      scpnl_pkg::BEAT_DIGIT: key_char = scpnl_pkg::CH_ZERO + {4'd0, head_job.digit};
      scpnl_pkg::BEAT_CR:    key_char = scpnl_pkg::CH_CR;
      default:               key_char = scpnl_pkg::CH_LF;
    endcase
  end

  always_comb begin
    out_valid_nxt = load || (out_valid_r && out_stall);
    beat_nxt      = beat_r;
    tx_valid_nxt  = tx_valid_r;
    tx_char_nxt   = tx_char_r;
    sel_nxt       = sel_r;
    seg_nxt       = seg_r;
    last_nxt      = last_r;
    if (load) begin
      beat_nxt     = last_beat ? '0 : beat_r + 1'b1;
      tx_valid_nxt = head_job.is_key;
      tx_char_nxt  = head_job.is_key ? key_char : 8'h00;
      sel_nxt      = head_job.sel;
      seg_nxt      = head_job.seg;
      last_nxt     = last_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      beat_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      beat_r      <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tx_valid_r <= tx_valid_nxt;
    tx_char_r  <= tx_char_nxt;
    sel_r      <= sel_nxt;
    seg_r      <= seg_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_tx_valid     = tx_valid_r;
  assign out_tx_char      = tx_char_r;
  assign out_digit_select = sel_r;
  assign out_segment_bits = seg_r;
  assign out_last_of_run  = last_r;

endmodule

### src/serial_command_seven_segment_panel_core.sv
`timescale 1ns / 1ps

// Serial command panel: takes one item (received byte, keypad code or scan
// tick) per cycle while the 4-entry job queue has room. Bytes, commands and
// display shifts are handled at acceptance; a scan tick yields one result
// beat and a valid key code yields seven (KEY:d CR LF), one beat per cycle
// from the output register while out_stall is low. Sustained rate is one
// item per cycle for scan ticks and serial bytes when out_stall stays low;
// a key report holds its queue entry until its last beat, one character beat a cycle.

module serial_command_seven_segment_panel_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_char,
  output logic [7:0] out_digit_select,
  output logic [7:0] out_segment_bits,
  output logic       out_last_of_run
);

  logic            q_full;
  logic            q_push;
  scpnl_pkg::job_t q_push_job;
  logic            q_pop;
  logic            q_empty;
  scpnl_pkg::job_t q_head_job;

  scpnl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_push_job   (q_push_job)
  );

  scpnl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (q_head_job)
  );

  scpnl_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .head_job         (q_head_job),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_valid     (out_tx_valid),
    .out_tx_char      (out_tx_char),
    .out_digit_select (out_digit_select),
    .out_segment_bits (out_segment_bits),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

### src/scpnl_checker.sv
`timescale 1ns / 1ps

module scpnl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_operation,
  input logic [7:0] in_data_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_tx_valid,
  input logic [7:0] out_tx_char,
  input logic [7:0] out_digit_select,
  input logic [7:0] out_segment_bits,
  input logic       out_last_of_run
);

  // held beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_char) &&
    $stable(out_digit_select) && $stable(out_last_of_run))
    else $error("stalled output beat changed");

  // scan results are single-beat runs
  a_scan_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_last_of_run)
    else $error("scan result not marked last");

  a_scan_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> $countones(~out_digit_select) == 1)
    else $error("scan digit select not one-cold");

  a_key_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid |-> out_digit_select == 8'hff && out_segment_bits == 8'h00)
    else $error("key report beat drives display fields");

  // report always ends with LF
  a_key_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid && out_last_of_run |-> out_tx_char == 8'h0a)
    else $error("key report ends with wrong character");

endmodule

bind serial_command_seven_segment_panel_core scpnl_checker u_scpnl_checker (.*);
